/* hdl/mlpp_pkg.sv */
// ---------------------------------------------------------------------------
// mlpp_pkg: types and constants of the level probe poller
// Shared payload structs, command codes and CRC step function.
// ---------------------------------------------------------------------------
package mlpp_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  probe_address;
    logic [31:0] oil_height;
    logic [31:0] water_height;
    logic [15:0] temp_one;
    logic [15:0] temp_two;
    logic [15:0] temp_three;
    logic [15:0] temp_four;
    logic [15:0] temp_five;
    logic        link_up;
  } out_item_t;

  // input function codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_BYTE = 2'd1;
  localparam logic [1:0] FUNC_IDLE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FIRST   = 3'd0;
  localparam logic [2:0] REG_LAST    = 3'd1;
  localparam logic [2:0] REG_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_START   = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;
  localparam logic [2:0] REG_FLIMIT  = 3'd5;

  localparam int unsigned GOOD_LENGTH = 27;
  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // front-to-back commands
  localparam logic [1:0] CMD_REQ  = 2'd0;
  localparam logic [1:0] CMD_EVAL = 2'd1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] addr;
    logic       link;
  } cmd_t;

  // one byte through the Modbus CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/modbus_level_probe_poller_core.sv */
// A tick that starts a poll gives eight request bytes, one a cycle while the
// result queue has room, after the front command register and the back state
// register have taken it; an evaluating tick gives its result once the
// byte-serial CRC walk over the buffer ends. Bytes and idle events leave the
// input ready; a tick that issues work holds it off until the command completes.
// Reset (rst_n low, synchronous) restores register defaults and empties all.
module modbus_level_probe_poller_core #(
  parameter int unsigned RX_BUFFER_DEPTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  mlpp_pkg::in_item_t   in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output mlpp_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import mlpp_pkg::*;

  localparam int unsigned LW = $clog2(RX_BUFFER_DEPTH);

  logic [7:0]  first_r, last_r;
  logic [15:0] tmo_r, start_r;
  logic [6:0]  count_r;
  logic [3:0]  flim_r;
  logic        cmd_valid, cmd_done, seen, link;
  cmd_t        cmd;
  logic [LW-1:0] rd_addr;
  logic [7:0]  rd_data, cur_addr;
  logic [LW:0] flen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 8'd225;
      last_r <= 8'd236;
      tmo_r <= 16'd70;
      start_r <= 16'd2;
      count_r <= 7'd11;
      flim_r <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST:   first_r <= cfg_data[7:0];
        REG_LAST:    last_r <= cfg_data[7:0];
        REG_TIMEOUT: tmo_r <= cfg_data;
        REG_START:   start_r <= cfg_data;
        REG_COUNT:   count_r <= cfg_data[6:0];
        REG_FLIMIT:  flim_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  mlpp_front #(.DEPTH(RX_BUFFER_DEPTH), .LW(LW)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .timeout_ticks(tmo_r), .cmd_valid, .cmd, .cmd_done,
    .cur_addr, .cur_link(link), .rd_addr, .rd_data,
    .frame_length(flen), .frame_seen(seen)
  );

  mlpp_back #(.LW(LW)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_done, .rd_addr, .rd_data,
    .frame_length(flen), .frame_seen(seen),
    .first_address(first_r), .last_address(last_r),
    .start_register(start_r), .register_count(count_r),
    .fail_limit(flim_r), .cfg_first_we(cfg_we && cfg_index == REG_FIRST),
    .cur_addr, .cur_link(link), .out_empty, .out_pop, .out_data
  );

endmodule

/* hdl/mlpp_front.sv */
// ---------------------------------------------------------------------------
// mlpp_front: event classifier
// Stores received bytes, tracks the wait and hands request or evaluation
// commands to the back end through a one-entry queue.
// ---------------------------------------------------------------------------
module mlpp_front #(
  parameter int unsigned DEPTH = 48,
  parameter int unsigned LW    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  mlpp_pkg::in_item_t   in_data,
  input  logic [15:0]          timeout_ticks,
  // command queue
  output logic                 cmd_valid,
  output mlpp_pkg::cmd_t       cmd,
  input  logic                 cmd_done,
  input  logic [7:0]           cur_addr,
  input  logic                 cur_link,
  // buffer read port for the back end
  input  logic [LW-1:0]        rd_addr,
  output logic [7:0]           rd_data,
  output logic [LW:0]          frame_length,
  output logic                 frame_seen
);
  import mlpp_pkg::*;

  logic [7:0]  mem [DEPTH];
  logic        waiting_r, waiting_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [LW:0] len_r, len_nxt;
  logic        seen_r, seen_nxt;
  logic        busy_r, busy_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        acc, is_eval;

  assign in_full = busy_r;
  assign acc = in_push && !busy_r;
  assign cmd_valid = busy_r;
  assign cmd = cmd_r;
  assign frame_length = len_r;
  assign frame_seen = seen_r;
  assign is_eval = busy_r && cmd_r.cmd == CMD_EVAL;

  always_ff @(posedge clk) begin
    if (acc && in_data.func == FUNC_BYTE && len_r < (LW+1)'(DEPTH)) begin
      mem[len_r[LW-1:0]] <= in_data.rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    waiting_nxt = waiting_r;
    wait_nxt = wait_r;
    len_nxt = len_r;
    seen_nxt = seen_r;
    busy_nxt = busy_r;
    cmd_nxt = cmd_r;
    if (busy_r && cmd_done) begin
      busy_nxt = 1'b0;
      if (is_eval) begin
        // evaluation empties the buffer
        len_nxt = '0;
        seen_nxt = 1'b0;
        waiting_nxt = 1'b0;
        wait_nxt = '0;
      end
    end
    if (acc) begin
      case (in_data.func)
        FUNC_BYTE: begin
          if (len_r < (LW+1)'(DEPTH)) len_nxt = len_r + 1'b1;
        end
        FUNC_IDLE: seen_nxt = 1'b1;
        FUNC_TICK: begin
          if (!waiting_r) begin
            busy_nxt = 1'b1;
            cmd_nxt = '{cmd: CMD_REQ, addr: cur_addr, link: cur_link};
            waiting_nxt = 1'b1;
            wait_nxt = '0;
          end else if (wait_r >= timeout_ticks) begin
            busy_nxt = 1'b1;
            cmd_nxt = '{cmd: CMD_EVAL, addr: cur_addr, link: cur_link};
          end else begin
            wait_nxt = wait_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      wait_r <= '0;
      len_r <= '0;
      seen_r <= 1'b0;
      busy_r <= 1'b0;
      cmd_r <= '0;
    end else begin
      waiting_r <= waiting_nxt;
      wait_r <= wait_nxt;
      len_r <= len_nxt;
      seen_r <= seen_nxt;
      busy_r <= busy_nxt;
      cmd_r <= cmd_nxt;
    end
  end

endmodule

/* hdl/mlpp_back.sv */
// ---------------------------------------------------------------------------
// mlpp_back: request builder and frame checker
// Streams request bytes, walks the stored frame for CRC and field
// extraction, updates link state and pushes results to a small queue.
// ---------------------------------------------------------------------------
module mlpp_back #(
  parameter int unsigned LW = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  mlpp_pkg::cmd_t        cmd,
  output logic                  cmd_done,
  output logic [LW-1:0]         rd_addr,
  input  logic [7:0]            rd_data,
  input  logic [LW:0]           frame_length,
  input  logic                  frame_seen,
  input  logic [7:0]            first_address,
  input  logic [7:0]            last_address,
  input  logic [15:0]           start_register,
  input  logic [6:0]            register_count,
  input  logic [3:0]            fail_limit,
  input  logic                  cfg_first_we,
  output logic [7:0]            cur_addr,
  output logic                  cur_link,
  output logic                  out_empty,
  input  logic                  out_pop,
  output mlpp_pkg::out_item_t   out_data
);
  import mlpp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REQ  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [4:0]  idx_r, idx_nxt;       // byte index
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  fr_r [GOOD_LENGTH];
  logic [7:0]  addr_r, addr_nxt;
  logic        link_r, link_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic        addr_init_r;
  out_item_t   q_r [2];
  logic        qv_r [2];
  logic        qpush;
  out_item_t   qin;
  logic [7:0]  rb;
  logic        good;
  logic [3:0]  finc;
  logic [8:0]  anext;

  assign cur_addr = addr_init_r ? addr_r : first_address;
  assign cur_link = link_r;
  assign out_empty = !qv_r[0];
  assign out_data = q_r[0];
  assign rd_addr = LW'(idx_r);
  assign cmd_done = (st_r == ST_DONE);

  // request byte by index
  always_comb begin
    case (idx_r[2:0])
      3'd0: rb = cmd.addr;
      3'd1: rb = FC_READ_HOLDING;
      3'd2: rb = start_register[15:8];
      3'd3: rb = start_register[7:0];
      3'd4: rb = 8'h00;
      3'd5: rb = {1'b0, register_count};
      3'd6: rb = crc_r[7:0];
      default: rb = crc_r[15:8];
    endcase
  end

  assign good = frame_seen && frame_length == (LW+1)'(GOOD_LENGTH)
                && fr_r[GOOD_LENGTH-2] == crc_r[7:0] && fr_r[GOOD_LENGTH-1] == crc_r[15:8];
  assign finc = fcnt_r + 1'b1;
  assign anext = {1'b0, cur_addr} + 9'd1;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    addr_nxt = cur_addr;
    link_nxt = link_r;
    fcnt_nxt = fcnt_r;
    qpush = 1'b0;
    qin = '0;
    qin.probe_address = cmd.addr;
    qin.link_up = cmd.link;
    case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
        crc_nxt = CRC_INIT;
        if (cmd_valid) st_nxt = (cmd.cmd == CMD_REQ) ? ST_REQ : ST_RD;
      end
      ST_REQ: begin
        // one byte per cycle while the result queue has room
        if (!qv_r[1]) begin
          qpush = 1'b1;
          qin.kind = KIND_REQ;
          qin.tx_byte = rb;
          qin.last = (idx_r == 5'd7);
          if (idx_r < 5'd6) crc_nxt = crc_byte(crc_r, rb);
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd7) st_nxt = ST_DONE;
        end
      end
      ST_RD: begin
        // read data is registered and arrives in the cycle after its address
        if (idx_r != 5'd0) begin
          if (idx_r <= 5'(GOOD_LENGTH - 2)) crc_nxt = crc_byte(crc_r, rd_data);
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 5'(GOOD_LENGTH)) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!qv_r[1]) begin
          qpush = 1'b1;
          qin.last = 1'b1;
          if (good) begin
            qin.kind = KIND_GOOD;
            qin.oil_height = {fr_r[3], fr_r[4], fr_r[5], fr_r[6]};
            qin.water_height = {fr_r[7], fr_r[8], fr_r[9], fr_r[10]};
            qin.temp_one = {fr_r[11], fr_r[12]};
            qin.temp_two = {fr_r[13], fr_r[14]};
            qin.temp_three = {fr_r[15], fr_r[16]};
            qin.temp_four = {fr_r[17], fr_r[18]};
            qin.temp_five = {fr_r[19], fr_r[20]};
            fcnt_nxt = '0;
            link_nxt = 1'b1;
          end else begin
            qin.kind = KIND_FAIL;
            addr_nxt = (anext > {1'b0, last_address}) ? first_address : anext[7:0];
            if (!link_r) begin
              fcnt_nxt = '0;
            end else if (finc >= fail_limit) begin
              fcnt_nxt = '0;
              link_nxt = 1'b0;
            end else begin
              fcnt_nxt = finc;
            end
          end
          qin.link_up = link_nxt;
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RD && idx_r != 5'd0) fr_r[idx_r - 5'd1] <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      idx_r <= '0;
      crc_r <= CRC_INIT;
      addr_r <= '0;
      addr_init_r <= 1'b0;
      link_r <= 1'b0;
      fcnt_r <= '0;
      qv_r[0] <= 1'b0;
      qv_r[1] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      link_r <= link_nxt;
      fcnt_r <= fcnt_nxt;
      // follow first_address until a poll or the first write of first_address latches it
      if (st_r == ST_FIN || (cfg_first_we && addr_init_r == 1'b0)) begin
        addr_r <= cfg_first_we && !addr_init_r ? cur_addr : addr_nxt;
        addr_init_r <= 1'b1;
      end
      if (qv_r[0] && out_pop) begin
        q_r[0] <= qv_r[1] ? q_r[1] : qin;
        qv_r[0] <= qv_r[1] || qpush;
        qv_r[1] <= qv_r[1] && qpush;
        if (qv_r[1] && qpush) q_r[1] <= qin;
      end else if (qpush) begin
        if (!qv_r[0]) begin
          q_r[0] <= qin;
          qv_r[0] <= 1'b1;
        end else begin
          q_r[1] <= qin;
          qv_r[1] <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/mlpp_checker.sv */
// ---------------------------------------------------------------------------
// mlpp_checker: port-level assertions of the poller
// Checks result transaction fields against each other over time.
// ---------------------------------------------------------------------------
module mlpp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input mlpp_pkg::out_item_t  out_data
);
  import mlpp_pkg::*;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind == KIND_FAIL) |-> out_data.oil_height == 32'd0 && out_data.last)
    else $error("failed poll carries data");

  a_good_link: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind == KIND_GOOD) |-> out_data.link_up && out_data.last)
    else $error("good reading without link");

  a_req_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind == KIND_REQ) |-> out_data.water_height == 32'd0)
    else $error("request byte carries data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind modbus_level_probe_poller_core mlpp_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_data
);
